FILE: rtl/ebtp_pkg.sv
// shared constants, register indexes, command codes and control struct
// for the encoder balanced turn pid core; no dependencies
package ebtp_pkg;

	// field and state widths
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 8;
	localparam int CMD_W           = 2;
	localparam int ANGLE_W         = 16;
	localparam int GAIN_W          = 16;
	localparam int SPEED_W         = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int TARGET_W        = 32;
	localparam int ERR_W           = 32;
	localparam int SUM_W           = 48;

	// product and sum widths of the correction path
	localparam int PT_W     = GAIN_W + 1 + ERR_W;
	localparam int DT_W     = GAIN_W + 2 + ERR_W;
	localparam int SPLIT_W  = SUM_W / 2;
	localparam int ITLO_W   = GAIN_W + SPLIT_W;
	localparam int ITHI_W   = GAIN_W + 1 + SUM_W - SPLIT_W;
	localparam int IT_W     = GAIN_W + SUM_W + 1;
	localparam int PD_W     = DT_W + 1;
	localparam int TOT_W    = IT_W + 2;
	localparam int IT_SHIFT = 60;

	// command codes
	localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENCODER = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CPD    = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd256;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd0;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd128;
	localparam logic [SPEED_W-1:0] BASE_RST   = 8'd180;
	localparam logic [GAIN_W-1:0]  CPD_RST    = 16'd3044;

	// saturation limits
	localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [IT_W-1:0]  IT_LIM  = IT_W'(1) << IT_SHIFT;
	localparam logic signed [IT_W-1:0]  IT_NLIM = -IT_LIM;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic pid;
		logic fin;
		logic turning;
		logic turn_right;
	} ctl_t;

endpackage

FILE: rtl/ebtp_track.sv
// front stage: encoder counts, turn target and active flag, first pipeline register
// depends on ebtp_pkg
module ebtp_track #(
	parameter int COUNT_WIDTH = ebtp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ebtp_pkg::CMD_W-1:0]          command,
	input  logic signed [ebtp_pkg::ANGLE_W-1:0] angle,
	input  logic                                encoder_side,
	input  logic                                phase_a,
	input  logic                                phase_b,
	input  logic [ebtp_pkg::GAIN_W-1:0]         counts_per_degree,
	input  logic                                adv_s2,
	output logic                                v_s1,
	output ebtp_pkg::ctl_t                      ctl_s1,
	output logic [COUNT_WIDTH-1:0]              mag_l_s1,
	output logic [COUNT_WIDTH-1:0]              mag_r_s1
);
	import ebtp_pkg::*;

	localparam int CMP_W  = (COUNT_WIDTH > TARGET_W) ? COUNT_WIDTH : TARGET_W;
	localparam int PROD_W = ANGLE_W + 1 + GAIN_W;

	logic [COUNT_WIDTH-1:0] left_cnt_q, right_cnt_q;
	logic [COUNT_WIDTH-1:0] left_mag_q, right_mag_q;
	logic [TARGET_W-1:0]    target_q;
	logic                   turn_right_q;
	logic                   active_q;

	logic                   take;
	logic                   is_start, is_enc, is_tick;
	logic [ANGLE_W:0]       ang_ext, ang_mag;
	logic [PROD_W-1:0]      tgt_prod;
	logic [TARGET_W-1:0]    target_new;
	logic                   turn_right_new;
	logic [COUNT_WIDTH-1:0] enc_cnt, enc_cnt_new, enc_mag_new;
	logic                   reached;
	logic                   active_next;
	ctl_t                   ctl_next;

	assign in_ready = !v_s1 || adv_s2;
	assign take     = in_valid && in_ready;

	// command decode
	always_comb begin
		is_start = 1'b0;
		is_enc   = 1'b0;
		is_tick  = 1'b0;
		unique case (command)
			CMD_START:   is_start = 1'b1;
			CMD_ENCODER: is_enc   = 1'b1;
			CMD_TICK:    is_tick  = 1'b1;
			default: ;
		endcase
	end

	// target from angle magnitude times counts per degree
	assign ang_ext        = {angle[ANGLE_W-1], angle};
	assign ang_mag        = angle[ANGLE_W-1] ? ('0 - ang_ext) : ang_ext;
	assign tgt_prod       = PROD_W'(ang_mag) * PROD_W'(counts_per_degree);
	assign target_new     = TARGET_W'(tgt_prod >> FRAC_BITS);
	assign turn_right_new = !angle[ANGLE_W-1] && (angle != '0);

	// quadrature step and magnitude of the new count
	assign enc_cnt     = encoder_side ? right_cnt_q : left_cnt_q;
	assign enc_cnt_new = (phase_a == phase_b) ? (enc_cnt + COUNT_WIDTH'(1))
	                                          : (enc_cnt - COUNT_WIDTH'(1));
	assign enc_mag_new = enc_cnt_new[COUNT_WIDTH-1] ? ('0 - enc_cnt_new) : enc_cnt_new;

	// end of turn when either wheel reaches the target
	assign reached = (CMP_W'(left_mag_q) >= CMP_W'(target_q)) ||
	                 (CMP_W'(right_mag_q) >= CMP_W'(target_q));

	always_comb begin
		active_next = active_q;
		if (is_start)
			active_next = 1'b1;
		else if (is_tick && active_q && reached)
			active_next = 1'b0;
	end

	always_comb begin
		ctl_next.pid        = is_tick && active_q && !reached;
		ctl_next.fin        = is_tick && active_q && reached;
		ctl_next.turning    = active_next;
		ctl_next.turn_right = is_start ? turn_right_new : turn_right_q;
	end

	// turn state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cnt_q   <= '0;
			right_cnt_q  <= '0;
			left_mag_q   <= '0;
			right_mag_q  <= '0;
			target_q     <= '0;
			turn_right_q <= 1'b0;
			active_q     <= 1'b0;
			v_s1         <= 1'b0;
		end else begin
			if (take) begin
				if (is_start) begin
					left_cnt_q   <= '0;
					right_cnt_q  <= '0;
					left_mag_q   <= '0;
					right_mag_q  <= '0;
					target_q     <= target_new;
					turn_right_q <= turn_right_new;
				end
				if (is_enc) begin
					if (encoder_side) begin
						right_cnt_q <= enc_cnt_new;
						right_mag_q <= enc_mag_new;
					end else begin
						left_cnt_q <= enc_cnt_new;
						left_mag_q <= enc_mag_new;
					end
				end
				active_q <= active_next;
			end
			if (in_ready)
				v_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_ready) begin
			ctl_s1   <= ctl_next;
			mag_l_s1 <= left_mag_q;
			mag_r_s1 <= right_mag_q;
		end
	end

endmodule

FILE: rtl/ebtp_pid.sv
// pid math pipeline, stages 2 to 5: error, derivative, integral and gain products
// depends on ebtp_pkg
module ebtp_pid #(
	parameter int COUNT_WIDTH = ebtp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             v_s1,
	input  ebtp_pkg::ctl_t                   ctl_s1,
	input  logic [COUNT_WIDTH-1:0]           mag_l_s1,
	input  logic [COUNT_WIDTH-1:0]           mag_r_s1,
	input  logic [ebtp_pkg::GAIN_W-1:0]      gain_p,
	input  logic [ebtp_pkg::GAIN_W-1:0]      gain_i,
	input  logic [ebtp_pkg::GAIN_W-1:0]      gain_d,
	input  logic                             adv_s6,
	output logic                             adv_s2,
	output logic                             v_s5,
	output ebtp_pkg::ctl_t                   ctl_s5,
	output logic signed [ebtp_pkg::PD_W-1:0] pd_s5,
	output logic signed [ebtp_pkg::IT_W-1:0] it_s5
);
	import ebtp_pkg::*;

	localparam int DIFF_W = (COUNT_WIDTH + 1 > ERR_W + 1) ? COUNT_WIDTH + 1 : ERR_W + 1;

	logic adv_s3, adv_s4, adv_s5;
	logic v_s2, v_s3, v_s4;

	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [SUM_W-1:0] err_sum_q;

	logic [DIFF_W-1:0]       diff;
	logic                    fits;
	logic signed [ERR_W-1:0] err_now;
	logic signed [ERR_W:0]   deriv_now;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [IT_W-1:0]  it_full, it_clamp;

	ctl_t                     ctl_s2, ctl_s3, ctl_s4;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [ERR_W:0]    deriv_s2;
	logic signed [PT_W-1:0]   pt_s3, pt_s4;
	logic signed [DT_W-1:0]   dt_s3, dt_s4;
	logic signed [SUM_W-1:0]  sum_s3;
	logic [ITLO_W-1:0]        it_lo_s4;
	logic signed [ITHI_W-1:0] it_hi_s4;

	// stage advance chain
	assign adv_s5 = !v_s5 || adv_s6;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;

	// wheel imbalance, saturated to the error range
	assign diff      = DIFF_W'(mag_l_s1) - DIFF_W'(mag_r_s1);
	assign fits      = (diff[DIFF_W-1:ERR_W-1] == {(DIFF_W-ERR_W+1){diff[DIFF_W-1]}});
	assign err_now   = fits ? $signed(diff[ERR_W-1:0]) : (diff[DIFF_W-1] ? ERR_MIN : ERR_MAX);
	assign deriv_now = (ERR_W+1)'(err_now) - (ERR_W+1)'(prev_err_q);

	// saturating integral
	assign sum_ext = (SUM_W+1)'(err_sum_q) + (SUM_W+1)'(err_s2);
	assign sum_new = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
	               ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];

	// integral term from its two partial products, then clamped
	assign it_full  = (IT_W'(it_hi_s4) <<< SPLIT_W) + $signed(IT_W'(it_lo_s4));
	assign it_clamp = (it_full > IT_LIM) ? IT_LIM : ((it_full < IT_NLIM) ? IT_NLIM : it_full);

	// loop state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			err_sum_q  <= '0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
		end else begin
			if (v_s1 && adv_s2 && ctl_s1.pid)
				prev_err_q <= err_now;
			if (v_s2 && adv_s3 && ctl_s2.pid)
				err_sum_q <= sum_new;
			if (adv_s2)
				v_s2 <= v_s1;
			if (adv_s3)
				v_s3 <= v_s2;
			if (adv_s4)
				v_s4 <= v_s3;
			if (adv_s5)
				v_s5 <= v_s4;
		end
	end

	// stage 2: error and derivative
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ctl_s2   <= ctl_s1;
			err_s2   <= err_now;
			deriv_s2 <= deriv_now;
		end
	end

	// stage 3: proportional and derivative products, new integral
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			ctl_s3 <= ctl_s2;
			pt_s3  <= PT_W'($signed({1'b0, gain_p})) * PT_W'(err_s2);
			dt_s3  <= DT_W'($signed({1'b0, gain_d})) * DT_W'(deriv_s2);
			sum_s3 <= sum_new;
		end
	end

	// stage 4: integral sum split into low and high halves, each times the integral gain
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			ctl_s4   <= ctl_s3;
			pt_s4    <= pt_s3;
			dt_s4    <= dt_s3;
			it_lo_s4 <= ITLO_W'(gain_i) * ITLO_W'(sum_s3[SPLIT_W-1:0]);
			it_hi_s4 <= ITHI_W'($signed({1'b0, gain_i})) *
			            ITHI_W'($signed(sum_s3[SUM_W-1:SPLIT_W]));
		end
	end

	// stage 5: clamped integral term and p plus d
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			ctl_s5 <= ctl_s4;
			pd_s5  <= PD_W'(pt_s4) + PD_W'(dt_s4);
			it_s5  <= it_clamp;
		end
	end

endmodule

FILE: rtl/ebtp_drive.sv
// output stage: base speed plus and minus correction, clamp, direction lines
// depends on ebtp_pkg
module ebtp_drive (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_s5,
	input  ebtp_pkg::ctl_t                    ctl_s5,
	input  logic signed [ebtp_pkg::PD_W-1:0]  pd_s5,
	input  logic signed [ebtp_pkg::IT_W-1:0]  it_s5,
	input  logic [ebtp_pkg::SPEED_W-1:0]      base_speed,
	output logic                              adv_s6,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ebtp_pkg::SPEED_W-1:0]      left_speed,
	output logic [ebtp_pkg::SPEED_W-1:0]      right_speed,
	output logic                              left_forward,
	output logic                              left_backward,
	output logic                              right_forward,
	output logic                              right_backward,
	output logic                              turning,
	output logic                              finished
);
	import ebtp_pkg::*;

	logic signed [TOT_W-1:0] base_fx, corr, v_left, v_right;

	// truncate toward zero and clamp a q-format drive level to 0..255
	function automatic logic [SPEED_W-1:0] drive_level(input logic signed [TOT_W-1:0] v);
		logic [SPEED_W-1:0] lvl;
		if (v[TOT_W-1] || (v == '0))
			lvl = '0;
		else if (|v[TOT_W-2:FRAC_BITS+SPEED_W])
			lvl = '1;
		else
			lvl = v[FRAC_BITS+SPEED_W-1:FRAC_BITS];
		return lvl;
	endfunction

	assign adv_s6  = !out_valid || out_ready;
	assign base_fx = $signed(TOT_W'(base_speed) << FRAC_BITS);
	assign corr    = TOT_W'(pd_s5) + TOT_W'(it_s5);
	assign v_left  = base_fx + corr;
	assign v_right = base_fx - corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv_s6)
			out_valid <= v_s5;
	end

	// result register; speeds and directions only on a pid tick
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			left_speed     <= ctl_s5.pid ? drive_level(v_left) : '0;
			right_speed    <= ctl_s5.pid ? drive_level(v_right) : '0;
			left_forward   <= ctl_s5.pid && ctl_s5.turn_right;
			right_backward <= ctl_s5.pid && ctl_s5.turn_right;
			left_backward  <= ctl_s5.pid && !ctl_s5.turn_right;
			right_forward  <= ctl_s5.pid && !ctl_s5.turn_right;
			turning        <= ctl_s5.turning;
			finished       <= ctl_s5.fin;
		end
	end

endmodule

FILE: rtl/encoder_balanced_turn_pid_core.sv
// encoder balanced turn pid core, top level: configuration registers and pipeline
// depends on ebtp_pkg, ebtp_track, ebtp_pid, ebtp_drive
//
// usage:
//   input channel (in_valid/in_ready) takes one item per transfer: a start command
//   with an angle, an encoder phase change, or a control tick. every item yields
//   exactly one result on the output channel (out_valid/out_ready), in order.
//   the configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no item is in flight. unknown indexes are ignored.
// throughput and stages:
//   one item is taken every cycle while the output is not stalled; each item
//   passes every pipeline stage register and then the result register. turn state
//   updates at the input transfer, the error and integral loops close in stages
//   two and three, and the integral product is split over two stages.
// reset:
//   arst_n clears counts, target, integral, last error and the active flag, loads
//   the register defaults and empties the pipeline.
// stall:
//   with out_valid high and out_ready low the result register holds; upstream
//   stages fill bubbles and in_ready drops only once every stage holds an item.
module encoder_balanced_turn_pid_core #(
	parameter int COUNT_WIDTH = ebtp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ebtp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ebtp_pkg::GAIN_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ebtp_pkg::CMD_W-1:0]          command,
	input  logic signed [ebtp_pkg::ANGLE_W-1:0] angle,
	input  logic                                encoder_side,
	input  logic                                phase_a,
	input  logic                                phase_b,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ebtp_pkg::SPEED_W-1:0]        left_speed,
	output logic [ebtp_pkg::SPEED_W-1:0]        right_speed,
	output logic                                left_forward,
	output logic                                left_backward,
	output logic                                right_forward,
	output logic                                right_backward,
	output logic                                turning,
	output logic                                finished
);
	import ebtp_pkg::*;

	logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q, cpd_q;
	logic [SPEED_W-1:0] base_q;

	logic                    v_s1, v_s5, adv_s2, adv_s6;
	ctl_t                    ctl_s1, ctl_s5;
	logic [COUNT_WIDTH-1:0]  mag_l_s1, mag_r_s1;
	logic signed [PD_W-1:0]  pd_s5;
	logic signed [IT_W-1:0]  it_s5;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
			base_q   <= BASE_RST;
			cpd_q    <= CPD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_BASE:   base_q   <= cfg_data[SPEED_W-1:0];
				REG_CPD:    cpd_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// counts, target and turn state
	ebtp_track #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.angle            (angle),
		.encoder_side     (encoder_side),
		.phase_a          (phase_a),
		.phase_b          (phase_b),
		.counts_per_degree(cpd_q),
		.adv_s2           (adv_s2),
		.v_s1             (v_s1),
		.ctl_s1           (ctl_s1),
		.mag_l_s1         (mag_l_s1),
		.mag_r_s1         (mag_r_s1)
	);

	// correction terms
	ebtp_pid #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_pid (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s1    (v_s1),
		.ctl_s1  (ctl_s1),
		.mag_l_s1(mag_l_s1),
		.mag_r_s1(mag_r_s1),
		.gain_p  (gain_p_q),
		.gain_i  (gain_i_q),
		.gain_d  (gain_d_q),
		.adv_s6  (adv_s6),
		.adv_s2  (adv_s2),
		.v_s5    (v_s5),
		.ctl_s5  (ctl_s5),
		.pd_s5   (pd_s5),
		.it_s5   (it_s5)
	);

	// wheel drive and result register
	ebtp_drive u_drive (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_s5          (v_s5),
		.ctl_s5        (ctl_s5),
		.pd_s5         (pd_s5),
		.it_s5         (it_s5),
		.base_speed    (base_q),
		.adv_s6        (adv_s6),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.left_forward  (left_forward),
		.left_backward (left_backward),
		.right_forward (right_forward),
		.right_backward(right_backward),
		.turning       (turning),
		.finished      (finished)
	);

endmodule
